FILE: sv/hcd_pkg.sv
// ============================================================================
// hcd_pkg
// Shared types, constants and helpers of the chunked body decoder.
// ============================================================================
`default_nettype none

package hcd_pkg;

    localparam int BYTE_W          = 8;
    localparam int SIZE_W          = 64;
    localparam int MAX_SIZE_DIGITS = 16;
    localparam int DCNT_W          = 5;
    localparam int HMATCH_W        = 2;
    localparam int TRAIL_W         = 2;
    localparam int STATUS_W        = 2;
    localparam int HEX_W           = 4;

    localparam logic [DCNT_W-1:0]   DCNT_SAT   = '1;
    localparam logic [HMATCH_W-1:0] HMATCH_END = '1;
    localparam logic [TRAIL_W-1:0]  TRAIL_LEN  = TRAIL_W'(2);

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [STATUS_W-1:0] ST_DECODING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LAST     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SIZE    = 3'd1,
        PH_SIZE_CR = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAIL   = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } hcd_phase_t;

    typedef struct packed {
        logic              first_byte;
        logic [BYTE_W-1:0] in_byte;
    } hcd_item_t;

    typedef struct packed {
        logic                emit;
        logic [BYTE_W-1:0]   out_byte;
        logic                is_body;
        logic [STATUS_W-1:0] status;
    } hcd_result_t;

    typedef struct packed {
        hcd_phase_t phase;
    } hcd_stat_t;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value.
    function automatic logic [HEX_W:0] hex_decode(input logic [BYTE_W-1:0] b);
        logic [HEX_W:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, HEX_W'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b1, HEX_W'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b1, HEX_W'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hcd_in_if.sv
// ============================================================================
// hcd_in_if
// Raw message byte channel: valid/ready with one byte and a restart mark.
// ============================================================================
`default_nettype none

interface hcd_in_if
    import hcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink   (input valid, input in_byte, input first_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/hcd_out_if.sv
// ============================================================================
// hcd_out_if
// Decoded result channel: valid/ready with byte, body flag and status.
// ============================================================================
`default_nettype none

interface hcd_out_if
    import hcd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                emit;
    logic [BYTE_W-1:0]   out_byte;
    logic                is_body;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output emit, output out_byte, output is_body,
                    output status, input ready);
    modport sink   (input valid, input emit, input out_byte, input is_body,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: sv/hcd_in_stage.sv
// ============================================================================
// hcd_in_stage
// Input register: captures one raw byte transaction per cycle unless stalled.
// ============================================================================
`default_nettype none

module hcd_in_stage
    import hcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hcd_in_if.sink     raw,
    input  wire logic  take,
    output hcd_item_t  item,
    output logic       item_valid
);

    logic      valid_reg;
    logic      valid_next;
    hcd_item_t item_reg;

    assign raw.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (raw.ready)
        begin
            valid_next = raw.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (raw.ready && raw.valid)
        begin
            item_reg <= '{first_byte: raw.first_byte, in_byte: raw.in_byte};
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

FILE: sv/hcd_parser.sv
// ============================================================================
// hcd_parser
// Parser state and single-pass byte update for chunked decoding.
// ============================================================================
`default_nettype none

module hcd_parser
    import hcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire hcd_item_t   item,
    input  wire logic        fire,
    output hcd_result_t      result,
    output hcd_stat_t        stat
);

    logic               hp_reg;
    hcd_phase_t         ph_reg,    ph_next;
    logic [HMATCH_W-1:0] hm_reg,   hm_next;
    logic [SIZE_W-1:0]  chunk_reg, chunk_next;
    logic [DCNT_W-1:0]  dcnt_reg,  dcnt_next;
    logic               ext_reg,   ext_next;
    logic [SIZE_W-1:0]  left_reg,  left_next;
    logic [TRAIL_W-1:0] trail_reg, trail_next;

    // state seen by this byte, after an optional restart
    hcd_phase_t          ph_cur;
    logic [HMATCH_W-1:0] hm_cur;
    logic [SIZE_W-1:0]   chunk_cur;
    logic [DCNT_W-1:0]   dcnt_cur;
    logic                ext_cur;
    logic [SIZE_W-1:0]   left_cur;
    logic [TRAIL_W-1:0]  trail_cur;

    logic [BYTE_W-1:0]  b;
    logic [HEX_W:0]     hex;
    logic [BYTE_W-1:0]  want;
    logic [SIZE_W-1:0]  left_dec;
    logic [TRAIL_W-1:0] trail_dec;

    assign b         = item.in_byte;
    assign hex       = hex_decode(b);
    assign want      = hm_cur[0] ? CHAR_LF : CHAR_CR;
    assign left_dec  = left_cur - SIZE_W'(1);
    assign trail_dec = (trail_cur != '0) ? trail_cur - TRAIL_W'(1) : trail_cur;

    always_comb
    begin
        if (item.first_byte)
        begin
            ph_cur    = hp_reg ? PH_HEADER : PH_SIZE;
            hm_cur    = '0;
            chunk_cur = '0;
            dcnt_cur  = '0;
            ext_cur   = 1'b0;
            left_cur  = '0;
            trail_cur = '0;
        end
        else
        begin
            ph_cur    = ph_reg;
            hm_cur    = hm_reg;
            chunk_cur = chunk_reg;
            dcnt_cur  = dcnt_reg;
            ext_cur   = ext_reg;
            left_cur  = left_reg;
            trail_cur = trail_reg;
        end
    end

    // next state
    always_comb
    begin
        ph_next    = ph_cur;
        hm_next    = hm_cur;
        chunk_next = chunk_cur;
        dcnt_next  = dcnt_cur;
        ext_next   = ext_cur;
        left_next  = left_cur;
        trail_next = trail_cur;
        unique case (ph_cur)
            PH_HEADER:
            begin
                if (b == want)
                begin
                    if (hm_cur == HMATCH_END)
                    begin
                        hm_next    = '0;
                        ph_next    = PH_SIZE;
                        chunk_next = '0;
                        dcnt_next  = '0;
                        ext_next   = 1'b0;
                    end
                    else
                    begin
                        hm_next = hm_cur + HMATCH_W'(1);
                    end
                end
                else
                begin
                    hm_next = (b == CHAR_CR) ? HMATCH_W'(1) : '0;
                end
            end
            PH_SIZE:
            begin
                if (b == CHAR_CR)
                begin
                    ph_next = PH_SIZE_CR;
                end
                else if (hex[HEX_W] && !ext_cur)
                begin
                    if (dcnt_cur < DCNT_W'(MAX_SIZE_DIGITS))
                    begin
                        chunk_next = {chunk_cur[SIZE_W-HEX_W-1:0], hex[HEX_W-1:0]};
                    end
                    if (dcnt_cur != DCNT_SAT)
                    begin
                        dcnt_next = dcnt_cur + DCNT_W'(1);
                    end
                end
                else
                begin
                    ext_next = 1'b1;
                end
            end
            PH_SIZE_CR:
            begin
                if (b == CHAR_LF)
                begin
                    if (dcnt_cur == '0 || dcnt_cur > DCNT_W'(MAX_SIZE_DIGITS))
                    begin
                        ph_next = PH_ERROR;
                    end
                    else if (chunk_cur == '0)
                    begin
                        ph_next = PH_DONE;
                    end
                    else
                    begin
                        left_next = chunk_cur;
                        ph_next   = PH_DATA;
                    end
                end
                else if (b == CHAR_CR)
                begin
                    ext_next = 1'b1;
                end
                else
                begin
                    ext_next = 1'b1;
                    ph_next  = PH_SIZE;
                end
            end
            PH_DATA:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    trail_next = TRAIL_LEN;
                    ph_next    = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
                trail_next = trail_dec;
                if (trail_dec == '0)
                begin
                    chunk_next = '0;
                    dcnt_next  = '0;
                    ext_next   = 1'b0;
                    ph_next    = PH_SIZE;
                end
            end
            default:
            begin
                ph_next = ph_cur;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        result = '0;
        unique case (ph_cur)
            PH_HEADER:
            begin
                result.emit     = 1'b1;
                result.out_byte = b;
            end
            PH_DATA:
            begin
                result.emit     = 1'b1;
                result.out_byte = b;
                result.is_body  = 1'b1;
            end
            default:
            begin
                result.emit = 1'b0;
            end
        endcase
        if (ph_next == PH_DONE)
        begin
            result.status = ST_LAST;
        end
        else if (ph_next == PH_ERROR)
        begin
            result.status = ST_ERROR;
        end
        else
        begin
            result.status = ST_DECODING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg    <= 1'b1;
            ph_reg    <= PH_HEADER;
            hm_reg    <= '0;
            chunk_reg <= '0;
            dcnt_reg  <= '0;
            ext_reg   <= 1'b0;
            left_reg  <= '0;
            trail_reg <= '0;
        end
        else if (cfg_we)
        begin
            hp_reg    <= cfg_wdata;
            ph_reg    <= cfg_wdata ? PH_HEADER : PH_SIZE;
            hm_reg    <= '0;
            chunk_reg <= '0;
            dcnt_reg  <= '0;
            ext_reg   <= 1'b0;
            left_reg  <= '0;
            trail_reg <= '0;
        end
        else if (fire)
        begin
            ph_reg    <= ph_next;
            hm_reg    <= hm_next;
            chunk_reg <= chunk_next;
            dcnt_reg  <= dcnt_next;
            ext_reg   <= ext_next;
            left_reg  <= left_next;
            trail_reg <= trail_next;
        end
    end

    assign stat.phase = ph_reg;

endmodule

`default_nettype wire

FILE: sv/hcd_out_stage.sv
// ============================================================================
// hcd_out_stage
// Result register: holds one decoded transaction until the sink takes it.
// ============================================================================
`default_nettype none

module hcd_out_stage
    import hcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire hcd_result_t result,
    output logic             take,
    hcd_out_if.source        dec
);

    logic        valid_reg;
    logic        valid_next;
    hcd_result_t res_reg;
    logic        advance;

    assign advance = !valid_reg || dec.ready;
    assign take    = item_valid && advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= result;
        end
    end

    assign dec.valid    = valid_reg;
    assign dec.emit     = res_reg.emit;
    assign dec.out_byte = res_reg.out_byte;
    assign dec.is_body  = res_reg.is_body;
    assign dec.status   = res_reg.status;

endmodule

`default_nettype wire

FILE: sv/http_chunked_body_decoder_top.sv
// ============================================================================
// http_chunked_body_decoder_top
// HTTP/1.1 chunked transfer decoder, one byte per transaction.
// ============================================================================
// Feed the raw message on raw, one byte per transaction, with first_byte set
// on the opening byte of each message to restart the parser. Every input
// transaction yields exactly one result transaction on dec: header bytes
// (while header_present is 1, up to and including the blank line) and chunk
// data bytes come out with emit set and is_body telling them apart; size
// lines and the two bytes after each chunk are dropped with emit clear.
// status reports 1 once the zero-size chunk is seen and 2 when a size line
// has no hex digits or more than 16; after that every byte is swallowed until
// the next restart. The block takes one byte per clock cycle while dec is not
// stalled: the whole per-byte update sits between an input register and a
// result register, and a new byte can enter the input register while a
// finished result still waits. Write header_present through cfg_we and
// cfg_wdata only while the block is idle; a write also restarts the parser.
// ============================================================================
`default_nettype none

module http_chunked_body_decoder_top
    import hcd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    hcd_in_if.sink    raw,
    hcd_out_if.source dec
);

    hcd_item_t   item;
    logic        item_valid;
    logic        take;
    hcd_result_t result;
    hcd_stat_t   stat;

    // capture the incoming transaction
    hcd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw        (raw),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    // advance the parser state as the byte moves into the result register
    hcd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .fire      (take),
        .result    (result),
        .stat      (stat)
    );

    // hold the result until the sink takes it
    hcd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .dec        (dec)
    );

    // A passed-on byte never coincides with the end of decoding.
    a_emit_status : assert property (@(posedge clk) disable iff (!rst_n)
        dec.valid && dec.emit |-> dec.status == ST_DECODING)
        else $error("byte passed on with a final status");

    // Body data is always flagged as emitted.
    a_body_emit : assert property (@(posedge clk) disable iff (!rst_n)
        dec.valid && dec.is_body |-> dec.emit)
        else $error("body flag without emit");

    // A register write restarts the parser in the matching phase.
    a_cfg_restart : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (($past(cfg_wdata) && stat.phase == PH_HEADER) ||
                    (!$past(cfg_wdata) && stat.phase == PH_SIZE)))
        else $error("parser not restarted by register write");

    // Back-pressure to the source only comes from a held input register.
    a_ready_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !raw.ready |-> item_valid && dec.valid && !dec.ready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

FILE: test/tb_http_chunked_body_decoder_top.sv
// ============================================================================
// tb_http_chunked_body_decoder_top
// Self-checking bench for the chunked body decoder.
// ============================================================================
// Drives whole messages (headers, size lines with and without extensions,
// chunk data, trailers, last chunks, bad size lines and plain noise) into the
// raw channel one byte per transaction. Random gaps are left on the raw side
// and random back-pressure is applied on the dec side. A scoreboard works out
// the decoder's answer for every accepted byte and compares it, field by
// field, with the result transactions in order.
// ============================================================================
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_top;
    import hcd_pkg::*;

    localparam int ITEM_TARGET    = 1550;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int IDLE_CYCLES    = 4;
    localparam int PRESSURE_AT    = 600;
    localparam int PRESSURE_LEN   = 150;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parser state of the decoder and holds the results
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class chunk_decode_scoreboard;
        bit                  hdr_mode;
        hcd_phase_t          phase;
        logic [HMATCH_W-1:0] blank_match;
        logic [SIZE_W-1:0]   size_acc;
        logic [DCNT_W-1:0]   ndigits;
        bit                  ext_seen;
        logic [SIZE_W-1:0]   remaining;
        logic [TRAIL_W-1:0]  skip_left;
        hcd_result_t         pending_results[$];
        int unsigned         mismatches;

        function new();
            hdr_mode   = 1'b1;
            mismatches = 0;
            restart();
        endfunction

        function void clear_line();
            size_acc = '0;
            ndigits  = '0;
            ext_seen = 1'b0;
        endfunction

        function void restart();
            phase       = hdr_mode ? PH_HEADER : PH_SIZE;
            blank_match = '0;
            remaining   = '0;
            skip_left   = '0;
            clear_line();
        endfunction

        function void set_header_mode(bit v);
            hdr_mode = v;
            restart();
        endfunction

        function bit hex_digit(logic [BYTE_W-1:0] b, output logic [HEX_W-1:0] v);
            v = b[3:0];
            if (b >= "0" && b <= "9")
                return 1'b1;
            v = b[3:0] + 4'd9;
            return (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
        endfunction

        // Size line has ended with CR LF: decide between data, last chunk
        // and a bad line.
        function void line_done();
            if (ndigits == 0 || ndigits > MAX_SIZE_DIGITS)
                phase = PH_ERROR;
            else if (size_acc == 0)
                phase = PH_DONE;
            else
            begin
                remaining = size_acc;
                phase     = PH_DATA;
            end
        endfunction

        function void size_char(logic [BYTE_W-1:0] b);
            logic [HEX_W-1:0] v;
            bit               is_hex;
            is_hex = hex_digit(b, v);
            if (b == CHAR_CR)
                phase = PH_SIZE_CR;
            else if (is_hex && !ext_seen)
            begin
                // keep only the leading digits, and count them until the counter saturates
                if (ndigits < MAX_SIZE_DIGITS)
                    size_acc = {size_acc[SIZE_W-HEX_W-1:0], v};
                if (ndigits != DCNT_SAT)
                    ndigits = ndigits + 1'b1;
            end
            else
                ext_seen = 1'b1;
        endfunction

        function hcd_result_t decode_byte(hcd_item_t it);
            hcd_result_t       r;
            logic [BYTE_W-1:0] b;
            logic [BYTE_W-1:0] want;
            b = it.in_byte;
            r = '0;
            if (it.first_byte)
                restart();
            case (phase)
                PH_HEADER:
                begin
                    want       = blank_match[0] ? CHAR_LF : CHAR_CR;
                    r.emit     = 1'b1;
                    r.out_byte = b;
                    if (b == want)
                    begin
                        if (blank_match == HMATCH_END)
                        begin
                            blank_match = '0;
                            phase       = PH_SIZE;
                            clear_line();
                        end
                        else
                            blank_match = blank_match + 1'b1;
                    end
                    else
                        blank_match = (b == CHAR_CR) ? HMATCH_W'(1) : '0;
                end
                PH_SIZE:
                    size_char(b);
                PH_SIZE_CR:
                begin
                    if (b == CHAR_LF)
                        line_done();
                    else if (b == CHAR_CR)
                        ext_seen = 1'b1;
                    else
                    begin
                        ext_seen = 1'b1;
                        phase    = PH_SIZE;
                    end
                end
                PH_DATA:
                begin
                    r.emit     = 1'b1;
                    r.out_byte = b;
                    r.is_body  = 1'b1;
                    remaining  = remaining - 1'b1;
                    if (remaining == 0)
                    begin
                        skip_left = TRAIL_LEN;
                        phase     = PH_TRAIL;
                    end
                end
                PH_TRAIL:
                begin
                    if (skip_left != 0)
                        skip_left = skip_left - 1'b1;
                    if (skip_left == 0)
                    begin
                        clear_line();
                        phase = PH_SIZE;
                    end
                end
                default:
                    ;
            endcase
            if (phase == PH_DONE)
                r.status = ST_LAST;
            else if (phase == PH_ERROR)
                r.status = ST_ERROR;
            else
                r.status = ST_DECODING;
            return r;
        endfunction

        function void note_byte(hcd_item_t it);
            pending_results.insert(pending_results.size(), decode_byte(it));
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        function void check_result(hcd_result_t got);
            hcd_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing pending: emit %0b byte %02h body %0b status %0d",
                         $time, got.emit, got.out_byte, got.is_body, got.status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.emit !== want.emit)
            begin
                $display("%0t: emit expected %0b, got %0b", $time, want.emit, got.emit);
                mismatches++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte,
                         got.out_byte);
                mismatches++;
            end
            if (got.is_body !== want.is_body)
            begin
                $display("%0t: is_body expected %0b, got %0b", $time, want.is_body, got.is_body);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hcd_in_if  raw_if ();
    hcd_out_if dec_if ();

    http_chunked_body_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .raw       (raw_if),
        .dec       (dec_if)
    );

    always #5 clk = ~clk;

    chunk_decode_scoreboard sb;

    hcd_item_t   msg_q[$];       // bytes of the message being built
    bit          next_first;     // restart mark for the next byte added
    int unsigned sent;           // raw transactions accepted so far
    int unsigned gap_pct;        // chance of a gap before a raw byte
    bit          long_hold_req;  // ask the receiver for one long hold-off
    int unsigned idle_cycles;

    // Gap length: mostly short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Idling level for a stretch: none, light or heavy.
    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Printable ASCII, never CR or LF.
    function automatic logic [BYTE_W-1:0] rand_text();
        return BYTE_W'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(logic [HEX_W-1:0] v, bit upper);
        if (v < 10)
            return BYTE_W'("0" + v);
        return BYTE_W'((upper ? "A" : "a") + v - 10);
    endfunction

    // ------------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------------
    task automatic add_byte(logic [BYTE_W-1:0] b);
        hcd_item_t it;
        it.first_byte = next_first;
        it.in_byte    = b;
        next_first    = 1'b0;
        msg_q.insert(msg_q.size(), it);
    endtask

    task automatic add_crlf();
        add_byte(CHAR_CR);
        add_byte(CHAR_LF);
    endtask

    // Header lines, sometimes with a stray CR or a near miss of the blank
    // line, closed by the blank line.
    task automatic add_header();
        int unsigned lines;
        int unsigned r;
        lines = $urandom_range(0, 3);
        if (lines == 0)
            add_crlf();
        repeat (lines)
        begin
            repeat ($urandom_range(1, 12))
                add_byte(($urandom_range(0, 19) == 0) ? rand_byte() : rand_text());
            r = $urandom_range(0, 9);
            if (r == 0)
                add_byte(CHAR_CR);
            else if (r == 1)
            begin
                add_crlf();
                add_byte(CHAR_CR);
                add_byte(rand_text());
            end
            add_crlf();
        end
        add_crlf();
    endtask

    // Tail of a size line: maybe an extension, a lone CR or a doubled CR,
    // then CR LF.
    task automatic add_line_end();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            add_byte(";");
            repeat ($urandom_range(0, 6))
                add_byte(rand_text());
        end
        else if (r == 3)
        begin
            add_byte(CHAR_CR);
            repeat ($urandom_range(1, 4))
                add_byte(rand_text());
        end
        else if (r == 4)
            add_byte(CHAR_CR);
        add_crlf();
    endtask

    task automatic add_size_digits(logic [SIZE_W-1:0] val, int ndig);
        logic [HEX_W-1:0] nib;
        for (int i = ndig - 1; i >= 0; i--)
        begin
            if (i < 16)
                nib = val[i*4 +: 4];
            else
                nib = '0;
            add_byte(hex_char(nib, 1'($urandom_range(0, 1))));
        end
    endtask

    // Size line for val with the fewest digits, sometimes padded with zeros
    // up to the digit limit.
    task automatic add_size_line(logic [SIZE_W-1:0] val);
        int need;
        int lead;
        need = 1;
        for (int i = 15; i > 0; i--)
        begin
            if (val[i*4 +: 4] != 0)
            begin
                need = i + 1;
                break;
            end
        end
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_SIZE_DIGITS - need) : 0;
        add_size_digits(val, need + lead);
        add_line_end();
    endtask

    task automatic build_message(bit hdr);
        int unsigned kind;
        int unsigned ending;
        int unsigned n;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // noise, sometimes carrying on from the previous message
            next_first = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 30))
                add_byte(rand_byte());
        end
        else if (hdr && kind < 12)
        begin
            // header that never reaches its blank line
            next_first = 1'b1;
            repeat ($urandom_range(5, 30))
                add_byte(rand_text());
        end
        else
        begin
            next_first = 1'b1;
            if (hdr)
                add_header();
            repeat ($urandom_range(1, 4))
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
                add_size_line(SIZE_W'(n));
                repeat (n)
                    add_byte(rand_byte());
                if ($urandom_range(0, 9) == 0)
                begin
                    add_byte(rand_byte());
                    add_byte(rand_byte());
                end
                else
                    add_crlf();
            end
            ending = $urandom_range(0, 99);
            if (ending < 70)
                add_size_line('0);
            else if (ending < 78)
                add_line_end();
            else if (ending < 86)
            begin
                add_size_digits({$urandom, $urandom}, $urandom_range(MAX_SIZE_DIGITS + 1, 20));
                add_line_end();
            end
            else if (ending < 93)
            begin
                // huge chunk, cut short by the next restart
                add_size_line({$urandom, $urandom});
                repeat ($urandom_range(1, 8))
                    add_byte(rand_byte());
            end
            if ($urandom_range(0, 9) < 4)
                repeat ($urandom_range(1, 5))
                    add_byte(rand_byte());
        end
    endtask

    // ------------------------------------------------------------------------
    // Driving: change inputs at the falling edge, sample at the rising edge
    // ------------------------------------------------------------------------
    task automatic send_byte(hcd_item_t it);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            raw_if.valid <= 1'b0;
            repeat (pick_gap())
                @(negedge clk);
        end
        raw_if.valid      <= 1'b1;
        raw_if.in_byte    <= it.in_byte;
        raw_if.first_byte <= it.first_byte;
        @(posedge clk);
        while (!raw_if.ready)
            @(posedge clk);
        sb.note_byte(it);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_message();
        foreach (msg_q[i])
            send_byte(msg_q[i]);
        msg_q.delete();
    endtask

    // Write the register only once the block has gone quiet.
    task automatic set_header_mode(bit v);
        raw_if.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(negedge clk);
        repeat (IDLE_CYCLES)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_header_mode(v);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        int unsigned stretch;
        int unsigned rx_pct;
        dec_if.ready = 1'b0;
        stall_left   = 0;
        stretch      = 0;
        rx_pct       = 15;
        forever
        begin
            @(negedge clk);
            stretch++;
            if (stretch == 200)
            begin
                stretch = 0;
                rx_pct  = pick_pct();
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                dec_if.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < rx_pct)
            begin
                stall_left = pick_gap() - 1;
                dec_if.ready <= 1'b0;
            end
            else
                dec_if.ready <= 1'b1;
        end
    end

    // Check every result transaction against the oldest pending one.
    always @(posedge clk)
    begin
        if (rst_n && dec_if.valid && dec_if.ready)
            sb.check_result({dec_if.emit, dec_if.out_byte, dec_if.is_body, dec_if.status});
    end

    // Watchdog: give up after too long with no transaction on either side.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((raw_if.valid && raw_if.ready) || (dec_if.valid && dec_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit          pressure_done;
        int unsigned pressure_until;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        raw_if.valid      = 1'b0;
        raw_if.in_byte    = '0;
        raw_if.first_byte = 1'b0;
        long_hold_req     = 1'b0;
        next_first        = 1'b0;
        sent              = 0;
        gap_pct           = 15;
        pressure_done     = 1'b0;
        pressure_until    = 0;
        sb                = new();

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Header mode out of reset: short header, one two-byte chunk holding
        // both byte extremes, last chunk, then a byte that must be swallowed.
        next_first = 1'b1;
        add_byte("A");
        add_crlf();
        add_crlf();
        add_byte("2");
        add_crlf();
        add_byte(8'h00);
        add_byte(8'hff);
        add_crlf();
        add_byte("0");
        add_crlf();
        add_byte("Z");
        send_message();

        // No header: digit after an extension, lone CR on the size line,
        // trailer bytes that are not CR LF, then a line with no digits.
        set_header_mode(1'b0);
        next_first = 1'b1;
        add_byte("1");
        add_byte(";");
        add_byte("A");
        add_byte(CHAR_CR);
        add_byte("Z");
        add_crlf();
        add_byte(8'h80);
        add_byte("Q");
        add_byte("Q");
        add_crlf();
        add_byte(8'h7f);
        send_message();
        set_header_mode(1'b1);

        // Random messages, switching header mode now and then.
        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                set_header_mode(1'($urandom_range(0, 1)));
            if (!pressure_done && sent >= PRESSURE_AT)
            begin
                // hold the result side off while bytes keep coming, so the
                // block fills and stalls its input
                pressure_done  = 1'b1;
                long_hold_req  = 1'b1;
                gap_pct        = 0;
                pressure_until = sent + PRESSURE_LEN;
            end
            else if (sent >= pressure_until)
                gap_pct = pick_pct();
            build_message(sb.hdr_mode);
            send_message();
        end

        raw_if.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
sv/hcd_pkg.sv
sv/hcd_in_if.sv
sv/hcd_out_if.sv
sv/hcd_in_stage.sv
sv/hcd_parser.sv
sv/hcd_out_stage.sv
sv/http_chunked_body_decoder_top.sv
test/tb_http_chunked_body_decoder_top.sv
